// File: hdl/qai_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qai_pkg
// Shared types, constants and helpers of the quaternion attitude integrator.
// ----------------------------------------------------------------------------
package qai_pkg;

    localparam int FRAC_BITS = 30;
    localparam int DW        = 32;              // component width
    localparam int PW        = 2 * DW;          // full product width
    localparam int AW        = DW + 4;          // derivative accumulator width
    localparam int QW        = FRAC_BITS + 1;   // quotient magnitude width
    localparam int QCW       = $clog2(QW + 1);  // divider step counter width

    localparam logic signed [DW-1:0] ONE_Q = DW'(1) <<< FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQ,
        ST_ROOT,
        ST_DIV,
        ST_DONE
    } state_t;

    // One product term of the first-order derivative.
    typedef struct packed {
        logic [1:0] qa;   // quaternion component 0=w 1=x 2=y 3=z
        logic [1:0] hs;   // half increment 0=x 1=y 2=z
        logic [1:0] dst;  // component it adds into
        logic       neg;  // subtract instead of add
    } term_t;

    localparam int NTERMS = 12;

    localparam term_t TERMS [NTERMS] = '{
        '{qa: 2'd1, hs: 2'd0, dst: 2'd0, neg: 1'b1},
        '{qa: 2'd2, hs: 2'd1, dst: 2'd0, neg: 1'b1},
        '{qa: 2'd3, hs: 2'd2, dst: 2'd0, neg: 1'b1},
        '{qa: 2'd0, hs: 2'd0, dst: 2'd1, neg: 1'b0},
        '{qa: 2'd3, hs: 2'd1, dst: 2'd1, neg: 1'b1},
        '{qa: 2'd2, hs: 2'd2, dst: 2'd1, neg: 1'b0},
        '{qa: 2'd0, hs: 2'd1, dst: 2'd2, neg: 1'b0},
        '{qa: 2'd1, hs: 2'd2, dst: 2'd2, neg: 1'b1},
        '{qa: 2'd3, hs: 2'd0, dst: 2'd2, neg: 1'b0},
        '{qa: 2'd0, hs: 2'd2, dst: 2'd3, neg: 1'b0},
        '{qa: 2'd2, hs: 2'd0, dst: 2'd3, neg: 1'b1},
        '{qa: 2'd1, hs: 2'd1, dst: 2'd3, neg: 1'b0}
    };

    // Handshake between the sequencer and an iterative unit.
    typedef struct packed {
        logic start;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    function automatic logic signed [DW-1:0] sat_acc(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = AW'({1'b0, {(DW-1){1'b1}}});
        lo = -hi - AW'(1);
        if (v > hi) begin
            sat_acc = {1'b0, {(DW-1){1'b1}}};
        end else if (v < lo) begin
            sat_acc = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sat_acc = v[DW-1:0];
        end
    endfunction

endpackage : qai_pkg
`default_nettype wire

// File: hdl/qai_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qai_mul
// Shared signed multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
module qai_mul
    import qai_pkg::*;
(
    input  wire                  aclk,
    input  wire signed [DW-1:0]  op_a,
    input  wire signed [DW-1:0]  op_b,
    output logic signed [PW-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule : qai_mul
`default_nettype wire

// File: hdl/qai_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qai_sqrt
// Iterative integer square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module qai_sqrt
    import qai_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  wire unit_ctl_t   ctl,
    input  wire  [PW-1:0]    radicand,
    output unit_sts_t        sts,
    output logic [DW-1:0]    root
);

    logic [PW-1:0] rem_reg,  rem_next;
    logic [PW-1:0] res_reg,  res_next;
    logic [PW-1:0] bit_reg,  bit_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (ctl.start) begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = PW'(1) << (PW - 2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_next = rem_reg - trial[PW-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign root     = res_reg[DW-1:0];

endmodule : qai_sqrt
`default_nettype wire

// File: hdl/qai_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qai_div
// Restoring divider for (mag << FRAC_BITS) / den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module qai_div
    import qai_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  wire unit_ctl_t   ctl,
    input  wire  [DW-1:0]    mag,
    input  wire  [DW-1:0]    den,
    output unit_sts_t        sts,
    output logic [QW-1:0]    quot
);

    logic [DW-1:0]  rem_reg,  rem_next;
    logic [QW-1:0]  src_reg,  src_next;
    logic [QW-1:0]  quo_reg,  quo_next;
    logic [DW-1:0]  den_reg,  den_next;
    logic [QCW-1:0] cnt_reg,  cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DW:0]    trial;

    // The quotient never exceeds one in fixed point, so the top part of the
    // shifted dividend is already below the divisor and seeds the remainder.
    always_comb begin
        rem_next  = rem_reg;
        src_next  = src_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, src_reg[QW-1]};
        if (ctl.start) begin
            rem_next  = mag >> 1;
            src_next  = {mag[0], {(QW-1){1'b0}}};
            quo_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            src_next = src_reg << 1;
            cnt_next = cnt_reg + QCW'(1);
            if (cnt_reg == QCW'(QW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        src_reg <= src_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = quo_reg;

endmodule : qai_div
`default_nettype wire

// File: hdl/quaternion_attitude_integrator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_attitude_integrator_top
// Orientation quaternion in Q2.30: load, or integrate a rotation increment and
// renormalize to unit length.
// ----------------------------------------------------------------------------
//  channel | bus         | contents
//  input   | s_tdata     | load_w, load_x, load_y, load_z, inc_x, inc_y, inc_z
//          | s_tuser     | mode
//  result  | m_tdata     | out_w, out_x, out_y, out_z
//          | m_tuser     | zero_norm
//
// A load item goes straight to the output register. An integrate item issues
// the twelve derivative terms, then the four squares on the shared multiplier,
// runs the bit-serial square root and the divider for each component, one
// after another, and loads the output register; a zero square sum skips root
// and divider. Reset sets the state to identity. s_tready is high only while
// the sequencer is idle; a result that is not taken holds in the output register.
// ----------------------------------------------------------------------------
module quaternion_attitude_integrator_top
    import qai_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [223:0] s_tdata,   // load_w, load_x, load_y, load_z, inc_x, inc_y, inc_z
    input  wire  [0:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [127:0] m_tdata,   // out_w, out_x, out_y, out_z
    output logic [0:0]   m_tuser    // zero_norm
);

    state_t state_reg, state_next;

    logic signed [DW-1:0] orient_reg [4];
    logic signed [DW-1:0] orient_next [4];
    logic signed [DW-1:0] half_reg [3];
    logic signed [AW-1:0] acc_reg [4];
    logic signed [AW-1:0] acc_next [4];
    logic signed [DW-1:0] c_reg [4];
    logic signed [DW-1:0] c_next [4];
    logic [PW:0]          sum_reg, sum_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [1:0]           comp_reg, comp_next;
    term_t                term_reg, term_next;
    logic                 zero_reg, zero_next;
    logic                 mv_reg, mv_next;
    logic [127:0]         md_reg, md_next;
    logic                 mu_reg, mu_next;

    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] term_val;
    logic [PW:0]          sum_add;
    logic [PW-1:0]        sum_sat;
    unit_ctl_t            sqrt_ctl, div_ctl;
    unit_sts_t            sqrt_sts, div_sts;
    logic [DW-1:0]        root;
    logic [QW-1:0]        quot;
    logic [DW-1:0]        div_mag;
    logic signed [DW-1:0] div_val;
    logic                 accept;

    qai_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod)
    );

    qai_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (sqrt_ctl),
        .radicand (sum_sat),
        .sts      (sqrt_sts),
        .root     (root)
    );

    qai_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .mag     (div_mag),
        .den     (root),
        .sts     (div_sts),
        .quot    (quot)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

    assign term_val = AW'(prod >>> FRAC_BITS);
    assign sum_add  = sum_reg + {1'b0, prod};
    assign sum_sat  = sum_add[PW] ? {PW{1'b1}} : sum_add[PW-1:0];
    // The divider samples its dividend when started, which is for the next component.
    assign div_mag  = c_reg[comp_next][DW-1] ? DW'(-c_reg[comp_next]) : c_reg[comp_next];
    assign div_val  = c_reg[comp_reg][DW-1] ? -DW'(quot) : DW'(quot);

    always_comb begin
        state_next = state_reg;
        orient_next = orient_reg;
        acc_next   = acc_reg;
        c_next     = c_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        term_next  = term_reg;
        zero_next  = zero_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        mu_next    = mu_reg;
        mul_a      = orient_reg[0];
        mul_b      = half_reg[0];
        sqrt_ctl   = '0;
        div_ctl    = '0;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    zero_next = 1'b0;
                    if (!s_tuser[0]) begin
                        orient_next[0] = s_tdata[31:0];
                        orient_next[1] = s_tdata[63:32];
                        orient_next[2] = s_tdata[95:64];
                        orient_next[3] = s_tdata[127:96];
                        state_next     = ST_DONE;
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            acc_next[i] = AW'(orient_reg[i]);
                        end
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // Issue one term a cycle and fold in the product issued before.
                if (cnt_reg < 4'(NTERMS)) begin
                    term_next = TERMS[cnt_reg];
                    mul_a     = orient_reg[TERMS[cnt_reg].qa];
                    mul_b     = half_reg[TERMS[cnt_reg].hs];
                end
                if (cnt_reg != '0) begin
                    acc_next[term_reg.dst] = term_reg.neg ? acc_reg[term_reg.dst] - term_val
                                                          : acc_reg[term_reg.dst] + term_val;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(NTERMS)) begin
                    for (int i = 0; i < 4; i++) begin
                        c_next[i] = sat_acc(acc_next[i]);
                    end
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                mul_a = c_reg[cnt_reg[1:0]];
                mul_b = c_reg[cnt_reg[1:0]];
                if (cnt_reg != '0) begin
                    sum_next = sum_add;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd4) begin
                    if (sum_add == '0) begin
                        for (int i = 0; i < 4; i++) begin
                            orient_next[i] = '0;
                        end
                        zero_next  = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        sqrt_ctl.start = 1'b1;
                        state_next     = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                if (sqrt_sts.done) begin
                    comp_next     = '0;
                    div_ctl.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    orient_next[comp_reg] = div_val;
                    comp_next = comp_reg + 2'd1;
                    if (comp_reg == 2'd3) begin
                        state_next = ST_DONE;
                    end else begin
                        div_ctl.start = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {orient_reg[3], orient_reg[2], orient_reg[1], orient_reg[0]};
                    mu_next    = zero_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            orient_reg[0] <= ONE_Q;
            orient_reg[1] <= '0;
            orient_reg[2] <= '0;
            orient_reg[3] <= '0;
            mv_reg        <= 1'b0;
            cnt_reg       <= '0;
            comp_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            orient_reg <= orient_next;
            mv_reg     <= mv_next;
            cnt_reg    <= cnt_next;
            comp_reg   <= comp_next;
        end
        if (accept) begin
            half_reg[0] <= $signed(s_tdata[159:128]) >>> 1;
            half_reg[1] <= $signed(s_tdata[191:160]) >>> 1;
            half_reg[2] <= $signed(s_tdata[223:192]) >>> 1;
        end
        acc_reg  <= acc_next;
        c_reg    <= c_next;
        sum_reg  <= sum_next;
        term_reg <= term_next;
        zero_reg <= zero_next;
        md_reg   <= md_next;
        mu_reg   <= mu_next;
    end

endmodule : quaternion_attitude_integrator_top
`default_nettype wire

// File: tb/quaternion_attitude_integrator_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_attitude_integrator_top_tb
// Self-checking bench for the quaternion integrator. A table of directed items goes
// in first, then random loads and integrate runs. Each result is checked against its
// typed row or a local attitude model, under random stalls on both sides until the last phase.
// ----------------------------------------------------------------------------
module quaternion_attitude_integrator_top_tb;
    import qai_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;

    typedef struct {
        logic        mode;
        logic [31:0] lw, lx, ly, lz, ix, iy, iz;
        logic        fixed;     // expected result typed into the row
        logic [31:0] ew, ex, ey, ez;
        logic        ezn;
    } stim_row_t;

    typedef struct {
        logic [127:0] quat;
        logic         zn;
    } attitude_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;

    int           send_idle_pct = 14;
    int           recv_idle_pct = 50;
    int           errors = 0;
    int           quiet_cycles = 0;
    logic         stim_done = 1'b0;
    attitude_t    expected_attitudes[$];
    logic signed [63:0] att_w, att_x, att_y, att_z;
    stim_row_t    directed[$];

    quaternion_attitude_integrator_top DUT (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] square_mag(input logic signed [63:0] v);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    function automatic logic [63:0] add_clamp(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        r = {1'b0, a} + {1'b0, b};
        return r[64] ? '1 : r[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > s) bits >>= 2;
        while (bits != 0) begin
            if (s >= res + bits) begin
                s = s - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res >>= 1;
            end
            bits >>= 2;
        end
        return res;
    endfunction

    // Advances the attitude state by one item and returns the result it shows.
    function automatic attitude_t advance_attitude(input logic mode,
                                                   input logic [223:0] d);
        attitude_t r;
        logic signed [63:0] hx, hy, hz, cw, cx, cy, cz, n;
        logic [63:0] s;
        r.zn = 1'b0;
        if (!mode) begin
            att_w = $signed(d[31:0]);
            att_x = $signed(d[63:32]);
            att_y = $signed(d[95:64]);
            att_z = $signed(d[127:96]);
        end else begin
            hx = $signed(d[159:128]) >>> 1;
            hy = $signed(d[191:160]) >>> 1;
            hz = $signed(d[223:192]) >>> 1;
            cw = clamp32(att_w - qmul(att_x, hx) - qmul(att_y, hy) - qmul(att_z, hz));
            cx = clamp32(att_x + qmul(att_w, hx) - qmul(att_z, hy) + qmul(att_y, hz));
            cy = clamp32(att_y + qmul(att_w, hy) - qmul(att_x, hz) + qmul(att_z, hx));
            cz = clamp32(att_z + qmul(att_w, hz) - qmul(att_y, hx) + qmul(att_x, hy));
            s = add_clamp(add_clamp(square_mag(cw), square_mag(cx)),
                          add_clamp(square_mag(cy), square_mag(cz)));
            if (s == 0) begin
                {att_w, att_x, att_y, att_z} = '0;
                r.zn = 1'b1;
            end else begin
                n = $signed(floor_sqrt(s));
                att_w = (cw <<< FRAC_BITS) / n;
                att_x = (cx <<< FRAC_BITS) / n;
                att_y = (cy <<< FRAC_BITS) / n;
                att_z = (cz <<< FRAC_BITS) / n;
            end
        end
        r.quat = {att_z[31:0], att_y[31:0], att_x[31:0], att_w[31:0]};
        return r;
    endfunction

    task automatic add_row(input logic mode, input logic [31:0] lw, lx, ly, lz,
                           input logic [31:0] ix, iy, iz, input logic fixed,
                           input logic [31:0] ew, ex, ey, ez, input logic ezn);
        stim_row_t r;
        r = '{mode, lw, lx, ly, lz, ix, iy, iz, fixed, ew, ex, ey, ez, ezn};
        directed.push_back(r);
    endtask

    // Drives one item and holds it until accepted; the prediction is queued then.
    // The valid stays high after acceptance until the sender idles or drives the next item.
    task automatic send_item(input logic mode, input logic [223:0] d,
                             input logic fixed, input attitude_t typed);
        attitude_t exp_res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        exp_res = advance_attitude(mode, d);
        if (fixed) exp_res = typed;
        expected_attitudes.push_back(exp_res);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h7FFF_FFFF);
            2: return 32'(int'($urandom_range(1 << 31)) - (1 << 30));
            default: return 32'(int'($urandom_range(1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [31:0] rand_inc();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'(int'($urandom_range(1 << 28)) - (1 << 27));
            default: return 32'(int'($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    // Receiver side with random stalls, result checking and the watchdog.
    always @(posedge aclk) begin
        attitude_t e;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles > WATCHDOG_CYCLES) begin
                $display("Mismatches found");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (expected_attitudes.size() == 0) begin
                    $display("%0t: unexpected result %h zn %b", $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    e = expected_attitudes.pop_front();
                    if (m_tdata !== e.quat || m_tuser[0] !== e.zn) begin
                        $display("%0t: expected %h zn %b, actual %h zn %b",
                                 $time, e.quat, e.zn, m_tdata, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        attitude_t typed;
        logic [223:0] d;
        stim_row_t r;
        int phase_items;
        int run_len;
        att_w = 64'sd1 <<< FRAC_BITS;
        {att_x, att_y, att_z} = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero increment from reset keeps identity exactly.
        add_row(1, 0, 0, 0, 0, 0, 0, 0, 1, 32'h4000_0000, 0, 0, 0, 0);
        add_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0,
                1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        add_row(1, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        // Zero length: the state collapses and stays zero.
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 32'h1000_0000, 0, 0, 1, 0, 0, 0, 0, 1);
        add_row(1, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 1);
        // All components at the negative extreme: the square sum saturates.
        add_row(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        add_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0,
                0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        add_row(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 32'h4000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 32'h0100_0000, 32'h0080_0000, 32'hFF00_0000, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        foreach (directed[i]) begin
            r = directed[i];
            typed.quat = {r.ez, r.ey, r.ex, r.ew};
            typed.zn = r.ezn;
            send_item(r.mode, {r.iz, r.iy, r.ix, r.lz, r.ly, r.lx, r.lw}, r.fixed, typed);
        end

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 50;
                recv_idle_pct = 14;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            phase_items = 0;
            while (phase_items < 280) begin
                // Mostly a load followed by a run of integrate steps.
                if ($urandom_range(9) < 8) begin
                    d = '0;
                    d[127:0] = {rand_q(), rand_q(), rand_q(), rand_q()};
                    if ($urandom_range(9) == 0) d[127:0] = $urandom_range(3) == 0 ? '0 :
                        {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF, 96'h0};
                    d[223:128] = {$urandom, $urandom, $urandom};
                    send_item(1'b0, d, 1'b0, typed);
                    phase_items++;
                end
                run_len = $urandom_range(1, 6);
                repeat (run_len) begin
                    d = {rand_inc(), rand_inc(), rand_inc(), $urandom, $urandom,
                         $urandom, $urandom};
                    send_item(1'b1, d, 1'b0, typed);
                    phase_items++;
                end
                if (phase_items > 140 && phase_items < 150) begin
                    s_tvalid <= 1'b0;
                    while (expected_attitudes.size() != 0) @(posedge aclk);
                end
            end
        end

        s_tvalid <= 1'b0;
        recv_idle_pct = 0;
        while (expected_attitudes.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0 && expected_attitudes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule : quaternion_attitude_integrator_top_tb
`default_nettype wire
